// ===== rtl/kscd_pkg.sv =====
package kscd_pkg;

   // table geometry
   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int KEY_W   = 16;
   localparam int QTY_W   = 16;
   localparam int ENTRY_W = KEY_W + QTY_W;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // function selector codes
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_REQUEST = 2'd1;
   localparam logic [1:0] FUNC_READ    = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_REQUEST,
      OP_READ,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [KEY_W-1:0] item_key;
      logic [QTY_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [KEY_W-1:0] key_out;
      logic [QTY_W-1:0] qty_out;
   } rsp_type;

   // classified command held in the queue
   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] item_key;
      logic [QTY_W-1:0] amount;
   } cmd_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic             idle;
      logic [CNT_W-1:0] count;
   } back_stat_type;

endpackage

// ===== rtl/kscd_ram.sv =====
module kscd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kscd_front.sv =====
module kscd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  kscd_pkg::req_type req_data,
   output logic              cmd_valid,
   output kscd_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);
   import kscd_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   cmd_type           cmd_in;
   logic              push_ok;
   logic              pop_ok;

   // classify the incoming word
   always_comb begin
      cmd_in.item_key = req_data.item_key;
      cmd_in.amount   = req_data.amount;
      case (req_data.func)
         FUNC_LOAD:    cmd_in.op = OP_LOAD;
         FUNC_REQUEST: cmd_in.op = OP_REQUEST;
         FUNC_READ:    cmd_in.op = OP_READ;
         default:      cmd_in.op = OP_BAD;
      endcase
   end

   assign req_full  = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + QCNT_W'(push_ok) - QCNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== rtl/kscd_back.sv =====
module kscd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  kscd_pkg::cmd_type       cmd_data,
   output logic                    cmd_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output kscd_pkg::rsp_type       rsp_data,
   output kscd_pkg::back_stat_type stat
);
   import kscd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_READ = 4'b0100,
      S_EMIT = 4'b1000
   } back_state_type;

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             hit_ff, hit_in;
   rsp_type          res_ff, res_in;
   rsp_type          out_ff, out_in;
   logic             out_vld_ff, out_vld_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               cur_hit;

   kscd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // entry under check matches and holds enough stock
   assign cur_hit = (ram_rdata[ENTRY_W-1:QTY_W] == cmd_ff.item_key) &&
                    (ram_rdata[QTY_W-1:0] >= cmd_ff.amount);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      chk_idx_in = chk_idx_ff;
      hit_in     = hit_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_pop;
      cmd_pop    = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = chk_idx_ff;
      ram_wdata  = {cmd_ff.item_key, ram_rdata[QTY_W-1:0] - cmd_ff.amount};
      ram_raddr  = idx_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               res_in   = '{status: ST_RANGE, key_out: '0, qty_out: '0};
               state_in = S_EMIT;
               case (cmd_data.op)
                  OP_LOAD: begin
                     if (count_ff < CNT_W'(DEPTH)) begin
                        ram_we        = 1'b1;
                        ram_waddr     = count_ff[IDX_W-1:0];
                        ram_wdata     = {cmd_data.item_key, cmd_data.amount};
                        count_in      = count_ff + 1'b1;
                        res_in.status = ST_OK;
                     end else begin
                        res_in.status = ST_FULL;
                     end
                  end
                  OP_REQUEST: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_SHORT;
                     end else begin
                        ram_raddr  = '0;
                        idx_in     = CNT_W'(1);
                        chk_idx_in = '0;
                        hit_in     = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (cmd_data.item_key < KEY_W'(count_ff)) begin
                        ram_raddr = cmd_data.item_key[IDX_W-1:0];
                        state_in  = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // one entry checked per cycle, next read issued alongside
         S_SCAN: begin
            ram_we = cur_hit;
            hit_in = hit_ff || cur_hit;
            if (idx_ff < count_ff) begin
               ram_raddr  = idx_ff[IDX_W-1:0];
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end else begin
               res_in.status = (hit_ff || cur_hit) ? ST_OK : ST_SHORT;
               state_in      = S_EMIT;
            end
         end
         S_READ: begin
            res_in   = '{status: ST_OK,
                         key_out: ram_rdata[ENTRY_W-1:QTY_W],
                         qty_out: ram_rdata[QTY_W-1:0]};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_vld_ff || rsp_pop) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      hit_ff     <= hit_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_empty  = !out_vld_ff;
   assign rsp_data   = out_ff;
   assign stat.idle  = (state_ff == S_IDLE);
   assign stat.count = count_ff;

endmodule

// ===== rtl/keyed_stock_check_and_decrement.sv =====
// Keyed stock table: up to DEPTH (key, quantity) entries in a single-port-write RAM.
// Request channel (req_push / req_full / req_data) is a queue write side; a word
// is taken at a clock edge with req_push high and req_full low. func selects load
// (append entry), stock request (decrement every matching entry with enough stock)
// or read (entry by index). Every word gives exactly one response word.
// Response channel (rsp_empty / rsp_pop / rsp_data) is a queue read side; the
// oldest response is shown while rsp_empty is low and leaves on rsp_pop.
// The engine takes a new command only after its last response has moved into the
// response register, so one command is in work at a time; a request walks the
// table one entry per cycle through the RAM read port, writing back the reduced
// quantity on the write port the cycle after the read.
// A two-word command queue sits between the decode front and the table engine.
// Reset empties the queue and the response register and zeroes the entry count;
// the table RAM is not cleared, as only entries below the count are ever read.
// When the receiver stalls the response register holds, the engine waits with
// its finished response, and the command queue fills until req_full rises.
module keyed_stock_check_and_decrement (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  kscd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output kscd_pkg::rsp_type rsp_data
);
   import kscd_pkg::*;

   logic          cmd_valid;
   cmd_type       cmd_data;
   logic          cmd_pop;
   back_stat_type back_stat;

   kscd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   kscd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .stat      (back_stat)
   );

   // no response survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response pending after reset");

   // engine only takes a command when one is queued
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("engine popped an empty command queue");

   // engine only takes a command while idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> back_stat.idle)
      else $error("engine popped a command while busy");

   // entry count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      back_stat.count <= CNT_W'(DEPTH))
      else $error("entry count beyond table depth");

   // entry count only ever steps up by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (back_stat.count != $past(back_stat.count)) |->
         (back_stat.count == $past(back_stat.count) + 1'b1))
      else $error("entry count changed by other than one");

endmodule
